// File: src/hs_pkg.sv
// ----------------------------------------------------------------------------
// HMAC-SHA1 engine package
// Shared constants, state encodings, helper functions and the command and
// status structures that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package hs_pkg;

   // Block and digest geometry in bytes, the round count and the last digest word index.
   localparam int BLK_BYTES  = 64;
   localparam int HASH_BYTES = 20;
   localparam int LEN_POS    = 56;
   localparam int ROUNDS     = 80;
   localparam int LAST_WORD  = 4;

   // HMAC pad bytes and the SHA-1 padding marker.
   localparam logic [7:0] IPAD_BYTE = 8'h36;
   localparam logic [7:0] OPAD_BYTE = 8'h5C;
   localparam logic [7:0] MARK_BYTE = 8'h80;

   // Request opcodes.
   localparam logic OP_KEY = 1'b0;
   localparam logic OP_MSG = 1'b1;

   // SHA-1 initial hash values.
   localparam logic [4:0][31:0] SHA_IV = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   // SHA-1 round constants.
   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   // Controller states.
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_STEP  = 7'b0000010,
      ST_PAD   = 7'b0000100,
      ST_CINIT = 7'b0001000,
      ST_ROUND = 7'b0010000,
      ST_CADD  = 7'b0100000,
      ST_OUTW  = 7'b1000000
   } state_type;

   // Where the block stands between key and message.
   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_SHORT = 4'b0010,
      PH_LONG  = 4'b0100,
      PH_MSG   = 4'b1000
   } phase_type;

   // Which hash the padding sequence is finishing.
   typedef enum logic [2:0] {
      FIN_KEY   = 3'b001,
      FIN_INNER = 3'b010,
      FIN_OUTER = 3'b100
   } fin_type;

   // Steps of the padding sequence.
   typedef enum logic [4:0] {
      PS_MARK  = 5'b00001,
      PS_ZERO  = 5'b00010,
      PS_LEN   = 5'b00100,
      PS_INNER = 5'b01000,
      PS_DONE  = 5'b10000
   } pad_step_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       shift_en;
      logic [7:0] shift_byte;
      logic       load_pad;
      logic [7:0] pad_byte;
      logic       load_inner;
      logic       set_iv;
      logic       comp_init;
      logic       round_en;
      logic [6:0] round_idx;
      logic       comp_add;
      logic       save_kpad_blk;
      logic       save_kpad_hash;
      logic       save_inner;
      logic       out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_busy;
   } status_type;

   function automatic logic [31:0] rotl1(input logic [31:0] x);
      return {x[30:0], x[31]};
   endfunction

   function automatic logic [31:0] rotl5(input logic [31:0] x);
      return {x[26:0], x[31:27]};
   endfunction

   function automatic logic [31:0] rotl30(input logic [31:0] x);
      return {x[1:0], x[31:2]};
   endfunction

endpackage

`default_nettype wire

// File: src/hs_req_if.sv
// ----------------------------------------------------------------------------
// HMAC-SHA1 request channel
// Valid/ready channel that carries one key or message byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface hs_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last;

   modport source (output valid, opcode, data_byte, has_byte, last, input ready);
   modport sink   (input valid, opcode, data_byte, has_byte, last, output ready);
endinterface

`default_nettype wire

// File: src/hs_rsp_if.sv
// ----------------------------------------------------------------------------
// HMAC-SHA1 result channel
// Valid/ready channel that carries one 32-bit digest word per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface hs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

// File: src/hmac_sha1_engine_core.sv
// ----------------------------------------------------------------------------
// HMAC-SHA1 engine core
// Streaming HMAC-SHA1: key bytes, then message bytes, digest out as words.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_if, one byte each. opcode 0 streams key bytes,
//   opcode 1 message bytes; last closes the key or the message, and has_byte
//   low with last high closes an empty one. The padded key is kept for all
//   later messages; a key over 64 bytes is hashed to 20 bytes first.
//   At the end of each message the five digest words leave on rsp_if, word 0
//   first, with last_word set on word 4.
// Sequencing:
//   One request is taken at a time. A byte is accepted, shifted in, and
//   the controller returns to idle; each full 64-byte block adds one SHA-1
//   compression (load, 80 rounds of the single round unit, chain add).
//   Closing a message costs padding bytes, one per cycle between
//   compressions, plus three or four compressions before word 0 is offered,
//   and one more compression when the closing request also opens the message.
// Reset and stall:
//   Reset gives an empty (all-zero) key and no message in progress. A
//   stalled receiver holds the digest in the output buffer; requests are still
//   taken until the next digest waits for the buffer to drain, then stall.
// ----------------------------------------------------------------------------
`default_nettype none

module hmac_sha1_engine_core (
   input  wire          clock,
   input  wire          reset,
   hs_req_if.sink       req_if,
   hs_rsp_if.source     rsp_if
);

   hs_pkg::cmd_type    cmd;
   hs_pkg::status_type status;

   // Controller: request handshake and sequencing.
   hs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_opcode    (req_if.opcode),
      .req_data_byte (req_if.data_byte),
      .req_has_byte  (req_if.has_byte),
      .req_last      (req_if.last),
      .status        (status),
      .cmd           (cmd)
   );

   // Datapath: buffers, SHA-1 round and result channel.
   hs_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_digest_word (rsp_if.digest_word),
      .rsp_word_index  (rsp_if.word_index),
      .rsp_last_word   (rsp_if.last_word)
   );

endmodule

`default_nettype wire

// File: src/hs_datapath.sv
// ----------------------------------------------------------------------------
// HMAC-SHA1 datapath
// Byte shift buffer and message schedule, padded key, chaining value, one
// SHA-1 round per cycle, and the digest output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module hs_datapath (
   input  wire                 clock,
   input  wire                 reset,
   input  hs_pkg::cmd_type     cmd,
   output hs_pkg::status_type  status,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output logic [31:0]         rsp_digest_word,
   output logic [2:0]          rsp_word_index,
   output logic                rsp_last_word
);

   logic [511:0]      blk_ff, blk_in;
   logic [511:0]      kpad_ff, kpad_in;
   logic [4:0][31:0]  chain_ff, chain_in;
   logic [4:0][31:0]  work_ff, work_in;
   logic [4:0][31:0]  inner_ff, inner_in;
   logic [4:0][31:0]  obuf_ff, obuf_in;
   logic [2:0]        oidx_ff, oidx_in;
   logic              ovalid_ff, ovalid_in;

   logic [31:0] w0, w2, w8, w13, wnew;
   logic [31:0] f_val, k_val, t_val;

   // Schedule window taps: word 0 of the window sits at the top of the buffer.
   assign w0   = blk_ff[511:480];
   assign w2   = blk_ff[447:416];
   assign w8   = blk_ff[255:224];
   assign w13  = blk_ff[95:64];
   assign wnew = hs_pkg::rotl1(w13 ^ w8 ^ w2 ^ w0);

   // Round function and constant for the current round.
   always_comb begin
      if (cmd.round_idx < 7'd20) begin
         f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         k_val = hs_pkg::K0;
      end else if (cmd.round_idx < 7'd40) begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = hs_pkg::K1;
      end else if (cmd.round_idx < 7'd60) begin
         f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3]) |
                 (work_ff[2] & work_ff[3]);
         k_val = hs_pkg::K2;
      end else begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = hs_pkg::K3;
      end
   end

   assign t_val = hs_pkg::rotl5(work_ff[0]) + f_val + work_ff[4] + k_val + w0;

   // Block buffer: byte shifts, pad and inner-digest loads, round word shifts.
   always_comb begin
      blk_in = blk_ff;
      priority if (cmd.shift_en) begin
         blk_in = {blk_ff[503:0], cmd.shift_byte};
      end else if (cmd.load_pad) begin
         blk_in = kpad_ff ^ {64{cmd.pad_byte}};
      end else if (cmd.load_inner) begin
         blk_in = {blk_ff[511:160], inner_ff[0], inner_ff[1], inner_ff[2],
                   inner_ff[3], inner_ff[4]};
      end else if (cmd.round_en) begin
         blk_in = {blk_ff[479:0], wnew};
      end else begin
         blk_in = blk_ff;
      end
   end

   // Padded key, chaining value, working variables and inner digest.
   always_comb begin
      kpad_in  = kpad_ff;
      chain_in = chain_ff;
      work_in  = work_ff;
      inner_in = inner_ff;
      if (cmd.save_kpad_blk) begin
         kpad_in = blk_ff;
      end else if (cmd.save_kpad_hash) begin
         kpad_in = {chain_ff[0], chain_ff[1], chain_ff[2], chain_ff[3], chain_ff[4],
                    352'd0};
      end
      if (cmd.set_iv) begin
         chain_in = hs_pkg::SHA_IV;
      end else if (cmd.comp_add) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
      if (cmd.comp_init) begin
         work_in = chain_ff;
      end else if (cmd.round_en) begin
         work_in[0] = t_val;
         work_in[1] = work_ff[0];
         work_in[2] = hs_pkg::rotl30(work_ff[1]);
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3];
      end
      if (cmd.save_inner) begin
         inner_in = chain_ff;
      end
   end

   // Output buffer hands the five digest words out one at a time.
   always_comb begin
      obuf_in   = obuf_ff;
      oidx_in   = oidx_ff;
      ovalid_in = ovalid_ff;
      if (cmd.out_load) begin
         obuf_in   = chain_ff;
         oidx_in   = 3'd0;
         ovalid_in = 1'b1;
      end else if (ovalid_ff && rsp_ready) begin
         oidx_in = oidx_ff + 3'd1;
         if (oidx_ff == 3'(hs_pkg::LAST_WORD)) begin
            ovalid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      blk_ff   <= blk_in;
      chain_ff <= chain_in;
      work_ff  <= work_in;
      inner_ff <= inner_in;
      obuf_ff  <= obuf_in;
      oidx_ff  <= oidx_in;
      if (reset) begin
         kpad_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         kpad_ff   <= kpad_in;
         ovalid_ff <= ovalid_in;
      end
   end

   assign rsp_valid       = ovalid_ff;
   assign rsp_digest_word = obuf_ff[oidx_ff];
   assign rsp_word_index  = oidx_ff;
   assign rsp_last_word   = (oidx_ff == 3'(hs_pkg::LAST_WORD));
   assign status.out_busy = ovalid_ff;

endmodule

`default_nettype wire

// File: src/hs_ctrl.sv
// ----------------------------------------------------------------------------
// HMAC-SHA1 controller
// Sequences key handling, message bytes, SHA-1 padding and compressions,
// and tracks the byte counts of the key and the message.
// ----------------------------------------------------------------------------
`default_nettype none

module hs_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire                 req_opcode,
   input  wire  [7:0]          req_data_byte,
   input  wire                 req_has_byte,
   input  wire                 req_last,
   input  hs_pkg::status_type  status,
   output hs_pkg::cmd_type     cmd
);

   localparam logic [6:0] FILL_FULL = 7'(hs_pkg::BLK_BYTES);
   localparam logic [6:0] FILL_LEN  = 7'(hs_pkg::LEN_POS);

   hs_pkg::state_type    state_ff, state_in;
   hs_pkg::phase_type    phase_ff, phase_in;
   hs_pkg::fin_type      fin_ff, fin_in;
   hs_pkg::pad_step_type step_ff, step_in;
   logic [6:0]  fill_ff, fill_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic [31:0] key_len_ff, key_len_in;
   logic [31:0] msg_len_ff, msg_len_in;
   logic        ret_pad_ff, ret_pad_in;
   logic [7:0]  byte_ff, byte_in;
   logic        p_kpre_ff, p_kpre_in;
   logic        p_kpost_ff, p_kpost_in;
   logic        p_mbeg_ff, p_mbeg_in;
   logic        p_byte_ff, p_byte_in;
   logic        p_mend_ff, p_mend_in;

   logic [31:0] fin_count;
   logic [63:0] len_bits, len_shifted;
   logic        in_key;

   assign in_key = (phase_ff == hs_pkg::PH_SHORT) || (phase_ff == hs_pkg::PH_LONG);

   // Byte count of the stream being finished, and its big-endian bit length.
   always_comb begin
      unique case (fin_ff)
         hs_pkg::FIN_KEY:   fin_count = key_len_ff;
         hs_pkg::FIN_INNER: fin_count = 32'(hs_pkg::BLK_BYTES) + msg_len_ff;
         hs_pkg::FIN_OUTER: fin_count = 32'(hs_pkg::BLK_BYTES + hs_pkg::HASH_BYTES);
         default:           fin_count = key_len_ff;
      endcase
   end

   assign len_bits    = {29'd0, fin_count, 3'd0};
   assign len_shifted = len_bits << {fill_ff[2:0], 3'b000};

   // Next-state and command logic.
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      fin_in     = fin_ff;
      step_in    = step_ff;
      fill_in    = fill_ff;
      rnd_in     = rnd_ff;
      key_len_in = key_len_ff;
      msg_len_in = msg_len_ff;
      ret_pad_in = ret_pad_ff;
      byte_in    = byte_ff;
      p_kpre_in  = p_kpre_ff;
      p_kpost_in = p_kpost_ff;
      p_mbeg_in  = p_mbeg_ff;
      p_byte_in  = p_byte_ff;
      p_mend_in  = p_mend_ff;
      cmd        = '0;
      cmd.round_idx = rnd_ff;
      req_ready  = 1'b0;

      unique case (state_ff)
         hs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && (req_has_byte || req_last)) begin
               byte_in  = req_data_byte;
               state_in = hs_pkg::ST_STEP;
               if (req_opcode == hs_pkg::OP_KEY) begin
                  // A key request outside a key starts a fresh key.
                  if (!in_key) begin
                     phase_in   = hs_pkg::PH_SHORT;
                     fill_in    = 7'd0;
                     key_len_in = 32'd0;
                  end
                  p_byte_in  = req_has_byte;
                  p_kpost_in = req_last;
               end else begin
                  p_kpre_in = in_key;
                  p_mbeg_in = (phase_ff != hs_pkg::PH_MSG);
                  p_byte_in = req_has_byte;
                  p_mend_in = req_last;
               end
            end
         end

         hs_pkg::ST_STEP: begin
            priority if (p_kpre_ff || (p_kpost_ff && !p_byte_ff)) begin
               // Close the key: hash a long key, or zero-align a short one.
               if (phase_ff == hs_pkg::PH_LONG) begin
                  fin_in     = hs_pkg::FIN_KEY;
                  step_in    = hs_pkg::PS_MARK;
                  state_in   = hs_pkg::ST_PAD;
                  p_kpre_in  = 1'b0;
                  p_kpost_in = 1'b0;
               end else if (fill_ff == FILL_FULL) begin
                  cmd.save_kpad_blk = 1'b1;
                  phase_in   = hs_pkg::PH_IDLE;
                  p_kpre_in  = 1'b0;
                  p_kpost_in = 1'b0;
               end else begin
                  cmd.shift_en = 1'b1;
                  fill_in      = fill_ff + 7'd1;
               end
            end else if (p_mbeg_ff) begin
               // Start the inner hash with the key XOR the inner pad.
               cmd.set_iv   = 1'b1;
               cmd.load_pad = 1'b1;
               cmd.pad_byte = hs_pkg::IPAD_BYTE;
               phase_in     = hs_pkg::PH_MSG;
               msg_len_in   = 32'd0;
               fill_in      = 7'd0;
               p_mbeg_in    = 1'b0;
               ret_pad_in   = 1'b0;
               state_in     = hs_pkg::ST_CINIT;
            end else if (p_byte_ff) begin
               if (fill_ff == FILL_FULL) begin
                  // A full buffer is compressed before the next byte enters.
                  if (phase_ff == hs_pkg::PH_SHORT) begin
                     cmd.set_iv = 1'b1;
                     phase_in   = hs_pkg::PH_LONG;
                  end
                  fill_in    = 7'd0;
                  ret_pad_in = 1'b0;
                  state_in   = hs_pkg::ST_CINIT;
               end else begin
                  cmd.shift_en   = 1'b1;
                  cmd.shift_byte = byte_ff;
                  fill_in        = fill_ff + 7'd1;
                  if (phase_ff == hs_pkg::PH_MSG) begin
                     msg_len_in = msg_len_ff + 32'd1;
                  end else begin
                     key_len_in = key_len_ff + 32'd1;
                  end
                  p_byte_in = 1'b0;
               end
            end else if (p_mend_ff) begin
               fin_in    = hs_pkg::FIN_INNER;
               step_in   = hs_pkg::PS_MARK;
               state_in  = hs_pkg::ST_PAD;
               p_mend_in = 1'b0;
            end else begin
               state_in = hs_pkg::ST_IDLE;
            end
         end

         hs_pkg::ST_PAD: begin
            if (fill_ff == FILL_FULL) begin
               fill_in    = 7'd0;
               ret_pad_in = 1'b1;
               state_in   = hs_pkg::ST_CINIT;
            end else begin
               unique case (step_ff)
                  hs_pkg::PS_MARK: begin
                     cmd.shift_en   = 1'b1;
                     cmd.shift_byte = hs_pkg::MARK_BYTE;
                     fill_in        = fill_ff + 7'd1;
                     step_in        = hs_pkg::PS_ZERO;
                  end
                  hs_pkg::PS_ZERO: begin
                     if (fill_ff == FILL_LEN) begin
                        step_in = hs_pkg::PS_LEN;
                     end else begin
                        cmd.shift_en = 1'b1;
                        fill_in      = fill_ff + 7'd1;
                     end
                  end
                  hs_pkg::PS_LEN: begin
                     cmd.shift_en   = 1'b1;
                     cmd.shift_byte = len_shifted[63:56];
                     fill_in        = fill_ff + 7'd1;
                     if (fill_ff[2:0] == 3'd7) begin
                        step_in = hs_pkg::PS_DONE;
                     end
                  end
                  hs_pkg::PS_INNER: begin
                     cmd.load_inner = 1'b1;
                     fill_in        = 7'(hs_pkg::HASH_BYTES);
                     step_in        = hs_pkg::PS_MARK;
                  end
                  hs_pkg::PS_DONE: begin
                     unique case (fin_ff)
                        hs_pkg::FIN_KEY: begin
                           cmd.save_kpad_hash = 1'b1;
                           phase_in = hs_pkg::PH_IDLE;
                           state_in = hs_pkg::ST_STEP;
                        end
                        hs_pkg::FIN_INNER: begin
                           // Keep the inner digest and start the outer hash.
                           cmd.save_inner = 1'b1;
                           cmd.set_iv     = 1'b1;
                           cmd.load_pad   = 1'b1;
                           cmd.pad_byte   = hs_pkg::OPAD_BYTE;
                           fin_in     = hs_pkg::FIN_OUTER;
                           step_in    = hs_pkg::PS_INNER;
                           fill_in    = 7'd0;
                           ret_pad_in = 1'b1;
                           state_in   = hs_pkg::ST_CINIT;
                        end
                        hs_pkg::FIN_OUTER: begin
                           state_in = hs_pkg::ST_OUTW;
                        end
                        default: begin
                           state_in = hs_pkg::ST_STEP;
                        end
                     endcase
                  end
                  default: begin
                     step_in = hs_pkg::PS_MARK;
                  end
               endcase
            end
         end

         hs_pkg::ST_CINIT: begin
            cmd.comp_init = 1'b1;
            rnd_in        = 7'd0;
            state_in      = hs_pkg::ST_ROUND;
         end

         hs_pkg::ST_ROUND: begin
            cmd.round_en = 1'b1;
            rnd_in       = rnd_ff + 7'd1;
            if (rnd_ff == 7'(hs_pkg::ROUNDS - 1)) begin
               state_in = hs_pkg::ST_CADD;
            end
         end

         hs_pkg::ST_CADD: begin
            cmd.comp_add = 1'b1;
            state_in     = ret_pad_ff ? hs_pkg::ST_PAD : hs_pkg::ST_STEP;
         end

         hs_pkg::ST_OUTW: begin
            // Hand the digest over once the previous one has drained.
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               phase_in     = hs_pkg::PH_IDLE;
               state_in     = hs_pkg::ST_STEP;
            end
         end

         default: begin
            state_in = hs_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (reset) begin
         state_ff   <= hs_pkg::ST_IDLE;
         phase_ff   <= hs_pkg::PH_IDLE;
         fin_ff     <= hs_pkg::FIN_KEY;
         step_ff    <= hs_pkg::PS_MARK;
         fill_ff    <= 7'd0;
         rnd_ff     <= 7'd0;
         key_len_ff <= 32'd0;
         msg_len_ff <= 32'd0;
         ret_pad_ff <= 1'b0;
         p_kpre_ff  <= 1'b0;
         p_kpost_ff <= 1'b0;
         p_mbeg_ff  <= 1'b0;
         p_byte_ff  <= 1'b0;
         p_mend_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         fin_ff     <= fin_in;
         step_ff    <= step_in;
         fill_ff    <= fill_in;
         rnd_ff     <= rnd_in;
         key_len_ff <= key_len_in;
         msg_len_ff <= msg_len_in;
         ret_pad_ff <= ret_pad_in;
         p_kpre_ff  <= p_kpre_in;
         p_kpost_ff <= p_kpost_in;
         p_mbeg_ff  <= p_mbeg_in;
         p_byte_ff  <= p_byte_in;
         p_mend_ff  <= p_mend_in;
      end
   end

   // The byte buffer never holds more than one block.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("block buffer fill count above one block");

   // Rounds only run with a round index inside the compression.
   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hs_pkg::ST_ROUND) |-> (rnd_ff < 7'(hs_pkg::ROUNDS)))
      else $error("round index beyond the last round");

   // A new digest is never loaded over one that is still being read out.
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !status.out_busy)
      else $error("digest loaded while output buffer busy");

   // A compression always ends in the add step after its last round.
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == hs_pkg::ST_ROUND) && (rnd_ff == 7'(hs_pkg::ROUNDS - 1)))
      |=> (state_ff == hs_pkg::ST_CADD))
      else $error("compression did not end in the add step");

endmodule

`default_nettype wire

// File: bench/hmac_sha1_engine_core_tb.sv
// ----------------------------------------------------------------------------
// HMAC-SHA1 engine core testbench
// Streams keys and messages with random gaps on both channels, computes the
// expected HMAC words with a behavioral SHA-1 and checks every digest word.
// ----------------------------------------------------------------------------
`default_nettype none

// Scoreboard: holds the engine state model and the queue of expected words.
class hmac_scoreboard;
   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last_word;
   } digest_type;

   localparam int PH_NONE = 0;
   localparam int PH_KSHORT = 1;
   localparam int PH_KLONG = 2;
   localparam int PH_MESSAGE = 3;

   logic [7:0]  key_pad [64];
   logic [31:0] key_count;
   logic [31:0] chain [5];
   logic [7:0]  blk [64];
   logic [31:0] msg_count;
   int          stage;
   digest_type  pending_words[$];
   int          errors;

   function new();
      foreach (key_pad[i]) key_pad[i] = 8'h00;
      foreach (blk[i]) blk[i] = 8'h00;
      key_count = 0;
      msg_count = 0;
      stage = PH_NONE;
      errors = 0;
      init_chain();
   endfunction

   function void init_chain();
      chain[0] = 32'h67452301; chain[1] = 32'hEFCDAB89; chain[2] = 32'h98BADCFE;
      chain[3] = 32'h10325476; chain[4] = 32'hC3D2E1F0;
   endfunction

   function void compress(logic [7:0] b [64]);
      logic [31:0] w [16];
      logic [31:0] a, bb, c, d, e, f, k, t32, tmp;
      for (int t = 0; t < 16; t++) w[t] = {b[4*t], b[4*t+1], b[4*t+2], b[4*t+3]};
      a = chain[0]; bb = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int t = 0; t < 80; t++) begin
         if (t >= 16) begin
            t32 = w[(t-3)&15] ^ w[(t-8)&15] ^ w[(t-14)&15] ^ w[t&15];
            w[t&15] = {t32[30:0], t32[31]};
         end
         if (t < 20) begin
            f = (bb & c) | (~bb & d); k = 32'h5A827999;
         end else if (t < 40) begin
            f = bb ^ c ^ d; k = 32'h6ED9EBA1;
         end else if (t < 60) begin
            f = (bb & c) | (bb & d) | (c & d); k = 32'h8F1BBCDC;
         end else begin
            f = bb ^ c ^ d; k = 32'hCA62C1D6;
         end
         tmp = {a[26:0], a[31:27]} + f + e + k + w[t&15];
         e = d; d = c; c = {bb[1:0], bb[31:2]}; bb = a; a = tmp;
      end
      chain[0] += a; chain[1] += bb; chain[2] += c; chain[3] += d; chain[4] += e;
   endfunction

   // Append the marker, zeros and bit length, then compress the tail.
   function void finish_hash(logic [31:0] count);
      int n;
      logic [63:0] bits;
      n = count & 63;
      bits = {29'd0, count, 3'd0};
      blk[n] = 8'h80;
      n++;
      if (n > 56) begin
         for (int i = n; i < 64; i++) blk[i] = 8'h00;
         compress(blk);
         n = 0;
      end
      for (int i = n; i < 56; i++) blk[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
      compress(blk);
   endfunction

   function void load_pad(logic [7:0] pad);
      for (int i = 0; i < 64; i++) blk[i] = key_pad[i] ^ pad;
   endfunction

   function void close_key();
      if (stage == PH_KLONG) begin
         finish_hash(key_count);
         foreach (key_pad[i]) key_pad[i] = 8'h00;
         for (int i = 0; i < 20; i++) key_pad[i] = chain[i/4][31-8*(i%4) -: 8];
      end
      stage = PH_NONE;
   endfunction

   function void add_key_byte(logic [7:0] v);
      if (stage == PH_KSHORT) begin
         if (key_count < 64) begin
            key_pad[key_count] = v;
            key_count++;
            return;
         end
         init_chain();
         compress(key_pad);
         stage = PH_KLONG;
      end
      blk[key_count & 63] = v;
      key_count++;
      if ((key_count & 63) == 0) compress(blk);
   endfunction

   // Note one accepted request and queue any digest words it produces.
   function void note_request(logic op, logic [7:0] v, logic has, logic last);
      logic [31:0] inner [5];
      if (!has && !last) return;
      if (op == hs_pkg::OP_KEY) begin
         if (stage != PH_KSHORT && stage != PH_KLONG) begin
            foreach (key_pad[i]) key_pad[i] = 8'h00;
            key_count = 0;
            stage = PH_KSHORT;
         end
         if (has) add_key_byte(v);
         if (last) close_key();
         return;
      end
      if (stage == PH_KSHORT || stage == PH_KLONG) close_key();
      if (stage != PH_MESSAGE) begin
         init_chain();
         load_pad(hs_pkg::IPAD_BYTE);
         compress(blk);
         msg_count = 0;
         stage = PH_MESSAGE;
      end
      if (has) begin
         blk[msg_count & 63] = v;
         msg_count++;
         if ((msg_count & 63) == 0) compress(blk);
      end
      if (!last) return;
      finish_hash(32'd64 + msg_count);
      inner = chain;
      init_chain();
      load_pad(hs_pkg::OPAD_BYTE);
      compress(blk);
      for (int i = 0; i < 20; i++) blk[i] = inner[i/4][31-8*(i%4) -: 8];
      finish_hash(32'd84);
      stage = PH_NONE;
      for (int i = 0; i < 5; i++) begin
         digest_type dw;
         dw.word = chain[i];
         dw.index = i[2:0];
         dw.last_word = (i == 4);
         pending_words.push_back(dw);
      end
   endfunction

   // Compare one accepted digest word with the oldest expectation.
   function void check_word(logic [31:0] word, logic [2:0] index, logic last_word);
      digest_type dw;
      if (pending_words.size() == 0) begin
         $error("unexpected digest word %h", word);
         errors++;
         return;
      end
      dw = pending_words.pop_front();
      if (word !== dw.word) begin
         $error("digest_word expected %h actual %h", dw.word, word);
         errors++;
      end
      if (index !== dw.index) begin
         $error("word_index expected %0d actual %0d", dw.index, index);
         errors++;
      end
      if (last_word !== dw.last_word) begin
         $error("last_word expected %0b actual %0b", dw.last_word, last_word);
         errors++;
      end
   endfunction
endclass

module hmac_sha1_engine_core_tb;

   logic clock;
   logic reset;
   bit   stall_long;
   bit   stim_done;

   hs_req_if req_if ();
   hs_rsp_if rsp_if ();

   hmac_scoreboard hmac_model;

   hmac_sha1_engine_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Short gaps or none, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Drive one request and hold it until the engine takes it.
   task automatic send_request(logic op, logic [7:0] v, logic has, logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.opcode    <= op;
      req_if.data_byte <= v;
      req_if.has_byte  <= has;
      req_if.last      <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      hmac_model.note_request(op, v, has, last);
      @(negedge clock);
   endtask

   task automatic send_sequence(logic op, int len, bit with_empty);
      for (int i = 0; i < len; i++) begin
         if (with_empty && $urandom_range(0, 9) == 0)
            send_request(op, 8'($urandom), 1'b0, 1'b0);
         send_request(op, 8'($urandom), 1'b1, i == len - 1);
      end
      if (len == 0) send_request(op, 8'($urandom), 1'b0, 1'b1);
   endtask

   // Random message size, usually short.
   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 9);
      if (r < 9) return $urandom_range(0, 12);
      return $urandom_range(56, 64);
   endfunction

   // Result side: random back-pressure, plus one long hold-off.
   initial begin
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         int gap;
         gap = pick_gap();
         if (stall_long) begin
            gap = 3000;
            stall_long = 1'b0;
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         hmac_model.check_word(rsp_if.digest_word, rsp_if.word_index, rsp_if.last_word);
   end

   // Stimulus: directed cases first, then random key and message streams.
   initial begin
      int wait_cycles;
      hmac_model = new();
      req_if.valid = 1'b0;
      req_if.opcode = hs_pkg::OP_KEY;
      req_if.data_byte = 8'h00;
      req_if.has_byte = 1'b0;
      req_if.last = 1'b0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty message under the reset key, and an ignored empty request.
      send_request(hs_pkg::OP_MSG, 8'hFF, 1'b0, 1'b0);
      send_request(hs_pkg::OP_MSG, 8'h00, 1'b0, 1'b1);
      // Short key with extreme bytes, closed by a message request.
      send_request(hs_pkg::OP_KEY, 8'h00, 1'b1, 1'b0);
      send_request(hs_pkg::OP_KEY, 8'hFF, 1'b1, 1'b0);
      send_request(hs_pkg::OP_MSG, 8'hAA, 1'b1, 1'b0);
      send_request(hs_pkg::OP_MSG, 8'h55, 1'b1, 1'b1);
      // Empty key, then a message dropped by a new key.
      send_request(hs_pkg::OP_KEY, 8'h12, 1'b0, 1'b1);
      send_request(hs_pkg::OP_MSG, 8'h34, 1'b1, 1'b0);
      send_request(hs_pkg::OP_KEY, 8'h80, 1'b1, 1'b1);
      send_request(hs_pkg::OP_MSG, 8'h01, 1'b1, 1'b1);
      // Over 64 key bytes, then a message whose padding spills a block.
      send_sequence(hs_pkg::OP_KEY, 65, 1'b0);
      send_sequence(hs_pkg::OP_MSG, 56, 1'b0);

      // Receiver holds off while whole messages keep coming in.
      stall_long = 1'b1;
      for (int m = 0; m < 4; m++) send_sequence(hs_pkg::OP_MSG, 2, 1'b0);

      // Random phase: mostly well-formed keys and messages.
      for (int n = 0; n < 4; n++) begin
         int r;
         r = $urandom_range(0, 9);
         if (r < 2)
            send_sequence(hs_pkg::OP_KEY, ($urandom_range(0, 2) == 0) ?
                          64 : $urandom_range(0, 12), 1'b1);
         else if (r < 3)
            send_request(1'($urandom_range(0, 1)), 8'($urandom),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         send_sequence(hs_pkg::OP_MSG, pick_len(), 1'b1);
      end
      req_if.valid <= 1'b0;

      // Drain, then allow for any trailing work.
      wait_cycles = 0;
      while (hmac_model.pending_words.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (500) @(posedge clock);
      if (hmac_model.errors == 0 && hmac_model.pending_words.size() == 0)
         $display("[hmac_sha1_engine_core] OK");
      else
         $display("[hmac_sha1_engine_core] ERROR");
      $finish;
   end

   initial begin
      #20000000;
      $display("[hmac_sha1_engine_core] ERROR");
      $finish;
   end
endmodule

`default_nettype wire

// File: files.f
src/hs_pkg.sv
src/hs_req_if.sv
src/hs_rsp_if.sv
src/hs_datapath.sv
src/hs_ctrl.sv
src/hmac_sha1_engine_core.sv
bench/hmac_sha1_engine_core_tb.sv
